### rtl/core/cimt_pkg.sv
// Shared constants, types and helper functions of the cyclic ideal minimality test.
package cimt_pkg;

   // Widest cycle length the sweep supports
   localparam int MAX_LENGTH = 16;
   localparam int MIN_LENGTH = 2;
   // Fixed field widths
   localparam int CAND_W = 16;
   localparam int LEN_W = 5;
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);
   // Derived widths
   localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int CMP_W = (MAX_LENGTH > CAND_W) ? MAX_LENGTH : CAND_W;
   // XOR tree split: rotations summed per group in the first stage
   localparam int GRP_SIZE = 4;
   localparam int NGRP = (MAX_LENGTH + GRP_SIZE - 1) / GRP_SIZE;

   typedef logic [MAX_LENGTH-1:0] word_type;
   typedef logic [CAND_W-1:0] cand_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef word_type [MAX_LENGTH-1:0] rot_table_type;

   // One multiplier word entering the product pipeline
   typedef struct packed {
      logic valid;
      logic last;
      word_type mult;
   } pipe_req_type;

   // One compare outcome leaving the product pipeline
   typedef struct packed {
      logic valid;
      logic last;
      logic hit;
   } pipe_res_type;

   // Low n bits set, word width
   function automatic word_type word_mask(input len_type n);
      word_type m;
      for (int i = 0; i < MAX_LENGTH; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

   // Low n bits set, candidate width
   function automatic cand_type cand_mask(input len_type n);
      cand_type m;
      for (int i = 0; i < CAND_W; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

endpackage

### rtl/core/cyclic_ideal_minimality_test.sv
// Top level of the cyclic ideal minimality test: length register, sequencer and product pipeline.
//
// Usage:
//   req channel: one word per candidate polynomial k (bit i is the coefficient of x^i).
//   rsp channel: one word per candidate, k if no folded product p*k mod x^n-1 is
//   nonzero and below k, otherwise 0.
//   csr channel: write of the cycle length n; values are clamped to 2..16. Write it
//   only while no candidate is in flight.
// Sequence and throughput:
//   After a candidate is accepted, k is folded into n bits and its rotation table is
//   built. The sweep then issues all 2^n multipliers, one multiplier per cycle, through
//   the three-stage product pipeline. The pipeline drains and the result is loaded into
//   the output register. One candidate is processed at a time, so the next candidate is
//   accepted only once the sequencer is idle again.
// Reset:
//   Synchronous, active high. Clears control state and sets n to 16.
// Stall:
//   A result waits in the output register while rsp_tready is low, and the next
//   candidate is accepted meanwhile. A finished sweep holds its answer until the
//   output register is free.
module cyclic_ideal_minimality_test
   import cimt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // Input words
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // [15:0] candidate
   // Result words
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] answer
   // Cycle length register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_data     // [4:0] cycle_length
);

   len_type       cycle_length_ff;
   len_type       cycle_len;
   pipe_req_type  pipe_req;
   pipe_res_type  pipe_res;
   rot_table_type rots;
   cand_type      cand;

   // Hold the length register
   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_length_ff <= LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         cycle_length_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   // Clamp the length into its working range
   always_comb begin
      if (cycle_length_ff < LEN_W'(MIN_LENGTH)) begin
         cycle_len = LEN_W'(MIN_LENGTH);
      end else if (cycle_length_ff > LEN_W'(MAX_LENGTH)) begin
         cycle_len = LEN_W'(MAX_LENGTH);
      end else begin
         cycle_len = cycle_length_ff;
      end
   end

   cimt_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cycle_len  (cycle_len),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cand   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_answer (rsp_tdata),
      .pipe_req   (pipe_req),
      .rots       (rots),
      .cand       (cand),
      .pipe_res   (pipe_res)
   );

   cimt_prod_pipe u_prod_pipe (
      .clock    (clock),
      .reset    (reset),
      .pipe_req (pipe_req),
      .rots     (rots),
      .cand     (cand),
      .pipe_res (pipe_res)
   );

endmodule

### rtl/core/cimt_prod_pipe.sv
// Three-stage pipeline: cyclic product of one multiplier with the folded candidate, then compare.
module cimt_prod_pipe
   import cimt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pipe_req_type  pipe_req,
   input  rot_table_type rots,
   input  cand_type      cand,
   output pipe_res_type  pipe_res
);

   logic                s1_valid_ff, s1_last_ff;
   word_type [NGRP-1:0] s1_grp_ff, s1_grp_in;
   logic                s2_valid_ff, s2_last_ff;
   word_type            s2_prod_ff, s2_prod_in;
   pipe_res_type        s3_res_ff, s3_res_in;

   // Stage one: gate each rotation by its multiplier bit, sum per group
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         s1_grp_in[g] = '0;
         for (int j = 0; j < GRP_SIZE; j++) begin
            if (g * GRP_SIZE + j < MAX_LENGTH) begin
               if (pipe_req.mult[g * GRP_SIZE + j]) begin
                  s1_grp_in[g] = s1_grp_in[g] ^ rots[g * GRP_SIZE + j];
               end
            end
         end
      end
   end

   // Stage two: combine the group sums into the folded product
   always_comb begin
      s2_prod_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         s2_prod_in = s2_prod_in ^ s1_grp_ff[g];
      end
   end

   // Stage three: flag a nonzero product below the candidate
   always_comb begin
      s3_res_in.valid = s2_valid_ff;
      s3_res_in.last  = s2_last_ff;
      s3_res_in.hit   = (s2_prod_ff != '0) && (CMP_W'(s2_prod_ff) < CMP_W'(cand));
   end

   // Advance valid bits with reset, payload without
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_res_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff     <= pipe_req.valid;
         s2_valid_ff     <= s1_valid_ff;
         s3_res_ff.valid <= s3_res_in.valid;
      end
      s1_last_ff     <= pipe_req.last;
      s1_grp_ff      <= s1_grp_in;
      s2_last_ff     <= s1_last_ff;
      s2_prod_ff     <= s2_prod_in;
      s3_res_ff.last <= s3_res_in.last;
      s3_res_ff.hit  <= s3_res_in.hit;
   end

   assign pipe_res = s3_res_ff;

endmodule

### rtl/core/cimt_seq.sv
// Sequencer: takes a candidate, folds it, builds its rotations, sweeps all multipliers.
module cimt_seq
   import cimt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  len_type       cycle_len,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  cand_type      req_cand,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output cand_type      rsp_answer,
   output pipe_req_type  pipe_req,
   output rot_table_type rots,
   output cand_type      cand,
   input  pipe_res_type  pipe_res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_ROT,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   cand_type      cand_ff, cand_in;
   cand_type      fold_ff, fold_in;
   word_type      cur_ff, cur_in;
   rot_table_type rots_ff, rots_in;
   logic [IDX_W-1:0] rot_cnt_ff, rot_cnt_in;
   word_type      mult_ff, mult_in;
   logic          hit_ff, hit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   cand_type      rsp_data_ff, rsp_data_in;

   cand_type      fold_hi, fold_lo;
   word_type      len_mask;
   logic [IDX_W-1:0] top_idx;
   logic          sweep_last;
   logic          slot_free;

   // Rotate left by one inside the low n bits
   function automatic word_type rot1(input word_type x, input word_type m,
                                     input logic [IDX_W-1:0] top);
      word_type r;
      r = (x << 1) & m;
      r[0] = x[top];
      return r;
   endfunction

   assign len_mask   = word_mask(cycle_len);
   assign top_idx    = IDX_W'(cycle_len - LEN_W'(1));
   assign fold_hi    = fold_ff >> cycle_len;
   assign fold_lo    = fold_ff & cand_mask(cycle_len);
   assign sweep_last = (mult_ff == len_mask);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      fold_in      = fold_ff;
      cur_in       = cur_ff;
      rots_in      = rots_ff;
      rot_cnt_in   = rot_cnt_ff;
      mult_in      = mult_ff;
      hit_in       = hit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pipe_req.valid = 1'b0;
      pipe_req.last  = sweep_last;
      pipe_req.mult  = mult_ff;

      // Collect compare outcomes
      if (pipe_res.valid && pipe_res.hit) begin
         hit_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cand_in  = req_cand;
               fold_in  = req_cand;
               hit_in   = 1'b0;
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            // Fold the high part down until the word fits in n bits
            if (fold_hi == '0) begin
               cur_in     = MAX_LENGTH'(fold_ff);
               rot_cnt_in = '0;
               state_in   = ST_ROT;
            end else begin
               fold_in = fold_lo ^ fold_hi;
            end
         end
         ST_ROT: begin
            // Shift rotations in; the first one pushed ends in entry zero
            for (int j = 0; j < MAX_LENGTH - 1; j++) begin
               rots_in[j] = rots_ff[j + 1];
            end
            rots_in[MAX_LENGTH-1] = cur_ff;
            cur_in     = rot1(cur_ff, len_mask, top_idx);
            rot_cnt_in = rot_cnt_ff + IDX_W'(1);
            if (rot_cnt_ff == IDX_W'(MAX_LENGTH - 1)) begin
               mult_in  = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // Issue one multiplier per cycle
            pipe_req.valid = 1'b1;
            mult_in        = mult_ff + MAX_LENGTH'(1);
            if (sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_res.valid && pipe_res.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold the answer until the output register is free
            if (slot_free) begin
               rsp_data_in  = hit_ff ? '0 : cand_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff     <= cand_in;
      fold_ff     <= fold_in;
      cur_ff      <= cur_in;
      rots_ff     <= rots_in;
      rot_cnt_ff  <= rot_cnt_in;
      mult_ff     <= mult_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_answer = rsp_data_ff;
   assign rots       = rots_ff;
   assign cand       = cand_ff;

`ifndef SYNTHESIS
   // Pipeline outcomes only arrive while sweeping or draining
   assert property (@(posedge clock) disable iff (reset)
      pipe_res.valid |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("pipeline result outside a sweep");

   // The final outcome closes the drain phase
   assert property (@(posedge clock) disable iff (reset)
      (pipe_res.valid && pipe_res.last) |-> (state_ff == ST_DRAIN))
      else $error("last pipeline result while not draining");

   // Rotated word never leaves the low n bits
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT) |-> ((cur_ff & ~len_mask) == '0))
      else $error("rotation word wider than cycle length");

   // Finishing with a free slot presents the answer next cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && slot_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("answer not presented after finish");
`endif

endmodule
